// File: design/assert_macros.svh
// Assertion macros used by the checker module of the batch sorter.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// An overlapping implication: when the antecedent holds, the consequent holds in the same cycle.
`define ABS_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// A next-cycle implication: when the antecedent holds, the consequent holds in the following cycle.
`define ABS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// File: design/abs_pkg.sv
// Shared types and constants of the ascending batch sorter.
package abs_pkg;

  localparam int DEPTH_DEFAULT         = 64;
  localparam int ELEMENT_WIDTH_DEFAULT = 32;
  localparam int VALUE_WIDTH           = 32;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_START,
    ST_LOAD,
    ST_SCAN,
    ST_PLACE,
    ST_EMIT
  } abs_state_t;

endpackage

// File: design/ascending_batch_sorter_unit.sv
// Top level of the ascending batch sorter: collection, in-memory insertion sort and read-out.
//
//   channel  | handshake          | payload
//   ---------+--------------------+---------------------------------------------
//   input    | start, busy        | in_value, in_last
//   result   | out_strobe         | out_sorted_value, out_last_res, out_overflow
//
// Items that do not end a batch are taken one per cycle when idle, stored while room is left.
// The item that ends a batch of n held elements starts an insertion sort in the store RAM:
// each element is loaded, larger ones before it move up (at most n(n-1)/2 moves in all) and
// it is placed, over one read and one write port; the n results then follow, one per cycle.
// Busy is high from the end of the batch until the last result is shown.
// Reset is synchronous and clears control state only; the store is not cleared.
// The receiver cannot stall, so each result stands on the ports for one cycle only.
module ascending_batch_sorter_unit #(
  parameter int DEPTH         = abs_pkg::DEPTH_DEFAULT,
  parameter int ELEMENT_WIDTH = abs_pkg::ELEMENT_WIDTH_DEFAULT
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  output logic                           busy,
  input  logic signed [abs_pkg::VALUE_WIDTH-1:0] in_value,
  input  logic                           in_last,
  output logic                           out_strobe,
  output logic signed [abs_pkg::VALUE_WIDTH-1:0] out_sorted_value,
  output logic                           out_last_res,
  output logic                           out_overflow
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam int VW = abs_pkg::VALUE_WIDTH;

  abs_pkg::abs_state_t state_r, state_nxt;

  logic [CW-1:0]            cnt_r, cnt_nxt;
  logic                     ovf_r, ovf_nxt;
  logic [AW-1:0]            i_r, i_nxt;
  logic [AW-1:0]            j_r, j_nxt;
  logic [AW-1:0]            k_r, k_nxt;
  logic [ELEMENT_WIDTH-1:0] cur_r, cur_nxt;
  logic                     out_strobe_r, out_last_r, out_ovf_r;

  logic                     accept;
  logic                     greater;
  logic                     has_room;
  logic [CW-1:0]            i_plus;
  logic                     emit_end;

  logic                     wr_en;
  logic [AW-1:0]            wr_addr;
  logic [ELEMENT_WIDTH-1:0] wr_data;
  logic                     rd_en;
  logic [AW-1:0]            rd_addr;
  logic [ELEMENT_WIDTH-1:0] rd_data;

  logic [63:0]              in_ext;
  logic signed [63:0]       out_ext;

  abs_ram #(
    .WIDTH (ELEMENT_WIDTH),
    .DEPTH (DEPTH)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign busy     = (state_r != abs_pkg::ST_IDLE);
  assign accept   = start && !busy;
  assign greater  = $signed(rd_data) > $signed(cur_r);
  assign has_room = cnt_r < CW'(DEPTH);
  assign i_plus   = CW'(i_r) + CW'(1);
  assign emit_end = (CW'(k_r) == (cnt_r - CW'(1)));
  assign in_ext   = {{32{in_value[VW-1]}}, in_value};
  assign out_ext  = 64'(signed'(rd_data));

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      abs_pkg::ST_IDLE: begin
        if (accept && in_last) begin
          state_nxt = abs_pkg::ST_START;
        end
      end
      abs_pkg::ST_START: begin
        state_nxt = (cnt_r < CW'(2)) ? abs_pkg::ST_EMIT : abs_pkg::ST_LOAD;
      end
      abs_pkg::ST_LOAD: begin
        state_nxt = abs_pkg::ST_SCAN;
      end
      abs_pkg::ST_SCAN: begin
        if (!greater || (j_r == AW'(1))) begin
          state_nxt = abs_pkg::ST_PLACE;
        end
      end
      abs_pkg::ST_PLACE: begin
        state_nxt = (i_plus == cnt_r) ? abs_pkg::ST_EMIT : abs_pkg::ST_LOAD;
      end
      abs_pkg::ST_EMIT: begin
        if (emit_end) begin
          state_nxt = abs_pkg::ST_IDLE;
        end
      end
      default: state_nxt = abs_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cnt_nxt = cnt_r;
    ovf_nxt = ovf_r;
    i_nxt   = i_r;
    j_nxt   = j_r;
    k_nxt   = k_r;
    cur_nxt = cur_r;
    wr_en   = 1'b0;
    wr_addr = j_r;
    wr_data = cur_r;
    rd_en   = 1'b0;
    rd_addr = k_r;
    unique case (state_r)
      abs_pkg::ST_IDLE: begin
        if (accept) begin
          if (has_room) begin
            wr_en   = 1'b1;
            wr_addr = cnt_r[AW-1:0];
            wr_data = in_ext[ELEMENT_WIDTH-1:0];
            cnt_nxt = cnt_r + CW'(1);
          end else begin
            ovf_nxt = 1'b1;
          end
          i_nxt = AW'(1);
          k_nxt = '0;
        end
      end
      abs_pkg::ST_START: begin
        rd_en   = 1'b1;
        rd_addr = i_r;
      end
      abs_pkg::ST_LOAD: begin
        cur_nxt = rd_data;
        rd_en   = 1'b1;
        rd_addr = i_r - AW'(1);
        j_nxt   = i_r;
      end
      abs_pkg::ST_SCAN: begin
        if (greater) begin
          wr_en   = 1'b1;
          wr_addr = j_r;
          wr_data = rd_data;
          j_nxt   = j_r - AW'(1);
          if (j_r != AW'(1)) begin
            rd_en   = 1'b1;
            rd_addr = j_r - AW'(1) - AW'(1);
          end
        end
      end
      abs_pkg::ST_PLACE: begin
        wr_en   = 1'b1;
        wr_addr = j_r;
        wr_data = cur_r;
        i_nxt   = i_plus[AW-1:0];
        if (i_plus != cnt_r) begin
          rd_en   = 1'b1;
          rd_addr = i_plus[AW-1:0];
        end
      end
      abs_pkg::ST_EMIT: begin
        rd_en   = 1'b1;
        rd_addr = k_r;
        k_nxt   = k_r + AW'(1);
        if (emit_end) begin
          cnt_nxt = '0;
          ovf_nxt = 1'b0;
        end
      end
      default: begin
        cnt_nxt = '0;
        ovf_nxt = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= abs_pkg::ST_IDLE;
      cnt_r        <= '0;
      ovf_r        <= 1'b0;
      i_r          <= '0;
      j_r          <= '0;
      k_r          <= '0;
      out_strobe_r <= 1'b0;
      out_last_r   <= 1'b0;
      out_ovf_r    <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      cnt_r        <= cnt_nxt;
      ovf_r        <= ovf_nxt;
      i_r          <= i_nxt;
      j_r          <= j_nxt;
      k_r          <= k_nxt;
      out_strobe_r <= (state_r == abs_pkg::ST_EMIT);
      out_last_r   <= (state_r == abs_pkg::ST_EMIT) && emit_end;
      out_ovf_r    <= (state_r == abs_pkg::ST_EMIT) && ovf_r;
    end
  end

  always_ff @(posedge clk) begin
    cur_r <= cur_nxt;
  end

  assign out_strobe       = out_strobe_r;
  assign out_sorted_value = out_ext[VW-1:0];
  assign out_last_res     = out_last_r;
  assign out_overflow     = out_ovf_r;

endmodule

// File: design/abs_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
module abs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// File: design/abs_checker.sv
// Port-level checker of the batch sorter and its binding to the top level.
`include "assert_macros.svh"

module abs_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        start,
  input logic        busy,
  input logic        in_last,
  input logic        out_strobe,
  input logic        out_last_res,
  input logic        out_overflow
);

  // The item that ends a batch must raise busy for the sort.
  `ABS_ASSERT_NEXT(a_last_sets_busy, clk, rst_n, start && !busy && in_last, busy, "busy did not rise after the final item of a batch")
  // The final-result mark never stands without its strobe.
  `ABS_ASSERT_SAME(a_last_has_strobe, clk, rst_n, out_last_res, out_strobe, "final-result mark without strobe")
  // Results before the final one are shown while the block is still busy.
  `ABS_ASSERT_SAME(a_mid_result_busy, clk, rst_n, out_strobe && !out_last_res, busy, "non-final result shown while idle")
  // The results of a batch come in consecutive cycles with one overflow flag.
  `ABS_ASSERT_NEXT(a_batch_contiguous, clk, rst_n, out_strobe && !out_last_res, out_strobe && $stable(out_overflow), "results of one batch broken up or overflow flag changed")
  // Nothing follows the final result in the next cycle.
  `ABS_ASSERT_NEXT(a_gap_after_last, clk, rst_n, out_strobe && out_last_res, !out_strobe, "result shown directly after the final result")

endmodule

bind ascending_batch_sorter_unit abs_checker u_abs_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .start        (start),
  .busy         (busy),
  .in_last      (in_last),
  .out_strobe   (out_strobe),
  .out_last_res (out_last_res),
  .out_overflow (out_overflow)
);
